/* rtl/capability_descriptor_checker_core_defines.svh */
// Assertion macros shared by the checker RTL
`ifndef CAPABILITY_DESCRIPTOR_CHECKER_CORE_DEFINES_SVH
`define CAPABILITY_DESCRIPTOR_CHECKER_CORE_DEFINES_SVH

// Assert that an antecedent implies a consequent in the same cycle
`define CDC_ASSERT_IMPL(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);

// Assert that an antecedent implies a consequent in the next cycle
`define CDC_ASSERT_NEXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);

`endif

/* rtl/cdc_pkg.sv */
// ----------------------------------------------------------------------------
// cdc_pkg
// Shared types, constants and helpers for the capability descriptor checker.
// ----------------------------------------------------------------------------
package cdc_pkg;

  localparam int TableDepth     = 64;
  localparam int AddrW          = $clog2(TableDepth);
  localparam int CountW         = $clog2(TableDepth + 1);
  localparam int RangeSizeLimit = 1048576;
  localparam logic [9:0] EmptyIrq = 10'h3FF;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_LOAD  = 2'd1,
    ACT_CHECK = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    ST_OK      = 4'd0,
    ST_KFLAGS  = 4'd1,
    ST_SYSCALL = 4'd2,
    ST_RANGE   = 4'd3,
    ST_PAGE    = 4'd4,
    ST_REGION  = 4'd5,
    ST_IRQ     = 4'd6,
    ST_APPTYPE = 4'd7,
    ST_KVER    = 4'd8,
    ST_HANDLES = 4'd9,
    ST_DEBUG   = 4'd10,
    ST_UNKNOWN = 4'd11
  } status_t;

  // Count trailing ones of a word (0..32)
  function automatic logic [5:0] kind_of(input logic [31:0] w);
    logic [5:0] n;
    logic       run;
    n   = 6'd0;
    run = 1'b1;
    for (int b = 0; b < 32; b++) begin
      if (run && w[b]) n = n + 6'd1;
      else run = 1'b0;
    end
    return n;
  endfunction

endpackage

/* rtl/cdc_if.sv */
// ----------------------------------------------------------------------------
// cdc_in_if / cdc_out_if
// Valid-ready channels for requests into and results out of the checker.
// ----------------------------------------------------------------------------
interface cdc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] word;
  logic        last_word;
  modport source (output valid, action, word, last_word, input ready);
  modport sink (input valid, action, word, last_word, output ready);
endinterface

interface cdc_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] status;
  logic       list_done;
  modport source (output valid, status, list_done, input ready);
  modport sink (input valid, status, list_done, output ready);
endinterface

/* rtl/cdc_ram.sv */
// ----------------------------------------------------------------------------
// cdc_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module cdc_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

/* rtl/cdc_eval.sv */
// ----------------------------------------------------------------------------
// cdc_eval
// Per-entry judging: folds one restriction word per cycle into match flags while step is high.
// ----------------------------------------------------------------------------
module cdc_eval (
  input  logic        clk,
  input  logic        start,   // clear the flags for a new check
  input  logic        step,    // one table entry is presented on entry
  input  logic [31:0] entry,
  input  logic [31:0] cap,     // capability word (second word for a range)
  input  logic [31:0] first,   // first word of a pending range pair
  input  logic        pair,    // cap is the second word of a range pair
  output logic        hit      // capability passes its rule so far
);

  logic [5:0]  ck, ek;
  logic        found;          // first entry of cap kind already seen
  logic        any_hit;
  logic        rng_half;       // set while the first word of a table pair is held
  logic [31:0] rng_r;
  logic        rng_fail;
  logic [2:0]  reg_ok;
  logic [1:0]  irq_ok;
  logic        e_hit, e_found;
  logic [2:0]  reg_hit;
  logic [1:0]  irq_hit;
  logic [24:0] start_a, end_a, re;
  logic [5:0]  rgn [3];
  logic        rro [3];
  logic [9:0]  id  [2];

  assign ck = pair ? 6'd6 : cdc_pkg::kind_of(cap);
  assign ek = cdc_pkg::kind_of(entry);

  // Judge a single entry for the first-match and any-match kinds
  always_comb begin
    e_hit   = 1'b0;
    e_found = 1'b0;
    case (ck)
      6'd3: begin
        e_found = (ek == 6'd3);
        e_hit = !(cap[15:10] < entry[15:10] || cap[9:4] > entry[9:4] ||
                  cap[15:10] > cap[9:4] || cap[23:16] < entry[23:16] ||
                  cap[31:24] > entry[31:24] || cap[23:16] > cap[31:24]);
      end
      6'd4: e_hit = (ek == 6'd4) && cap[31:29] == entry[31:29] &&
                    cap[28:5] == entry[28:5];
      6'd7: e_hit = (ek == 6'd7) && entry == cap;
      6'd13, 6'd14: begin
        e_found = (ek == ck);
        e_hit   = (entry == cap);
      end
      6'd15: begin
        e_found = (ek == 6'd15);
        e_hit   = cap[25:16] <= entry[25:16];
      end
      6'd16: begin
        e_found = (ek == 6'd16);
        e_hit   = ((entry & cap) == cap);
      end
      default: ;
    endcase
  end

  // Region and interrupt slots
  always_comb begin
    rgn[0] = cap[16:11]; rro[0] = cap[17];
    rgn[1] = cap[23:18]; rro[1] = cap[24];
    rgn[2] = cap[30:25]; rro[2] = cap[31];
    id[0]  = cap[21:12]; id[1]  = cap[31:22];
    for (int s = 0; s < 3; s++) begin
      reg_hit[s] = 1'b0;
      for (int t = 0; t < 3; t++)
        if (entry[11+7*t +: 6] == rgn[s] && (rro[s] || !entry[17+7*t]))
          reg_hit[s] = 1'b1;
      reg_hit[s] = reg_hit[s] && (ek == 6'd10);
    end
    for (int s = 0; s < 2; s++)
      irq_hit[s] = (ek == 6'd11) && ((entry[21:12] == cdc_pkg::EmptyIrq &&
                   entry[31:22] == cdc_pkg::EmptyIrq) ||
                   entry[21:12] == id[s] || entry[31:22] == id[s]);
  end

  // Range containment against the current table pair
  assign start_a = {1'b0, first[30:7]};
  assign end_a   = start_a + {1'b0, cap[30:7]};
  assign re      = {1'b0, rng_r[30:7]} + {1'b0, entry[30:7]};

  // Fold flags entry by entry
  always_ff @(posedge clk) begin
    if (start) begin
      found    <= 1'b0;
      any_hit  <= 1'b0;
      rng_half <= 1'b0;
      rng_fail <= 1'b0;
      reg_ok   <= {cap[30:25] == 6'd0, cap[23:18] == 6'd0, cap[16:11] == 6'd0};
      irq_ok   <= 2'b00;
    end else if (step) begin
      if (!found && e_found) begin
        found   <= 1'b1;
        any_hit <= e_hit;
      end
      if (ck == 6'd4 || ck == 6'd7) any_hit <= any_hit | e_hit;
      reg_ok <= reg_ok | reg_hit;
      irq_ok <= irq_ok | irq_hit;
      // Walk table pairs in order; stop at the first fit or a broken pair
      if (pair && !rng_fail && !any_hit) begin
        if (rng_half) begin
          rng_half <= 1'b0;
          if (ek != 6'd6) rng_fail <= 1'b1;
          else if ({1'b0, entry[30:7]} < 25'(cdc_pkg::RangeSizeLimit) &&
                   first[31] == rng_r[31] && cap[31] == entry[31] &&
                   {1'b0, rng_r[30:7]} <= start_a && start_a <= re && end_a <= re)
            any_hit <= 1'b1;
        end else if (ek == 6'd6) begin
          rng_half <= 1'b1;
          rng_r    <= entry;
        end
      end
    end
  end

  // Final verdict for the capability kind
  always_comb begin
    case (ck)
      6'd3, 6'd4, 6'd7, 6'd13, 6'd14, 6'd15: hit = any_hit;
      6'd16: hit = any_hit && ({2'b0, cap[17]} + {2'b0, cap[18]} + {2'b0, cap[19]} <= 3'd1);
      6'd10: hit = &reg_ok;
      6'd11: hit = &irq_ok;
      6'd6: hit = pair && any_hit && cdc_pkg::kind_of(cap) == 6'd6 &&
                  {1'b0, cap[30:7]} < 25'(cdc_pkg::RangeSizeLimit);
      default: hit = 1'b0;
    endcase
  end

endmodule

/* rtl/capability_descriptor_checker_core.sv */
// A check walks the table, registers its status in S_DONE and shows it in S_OUT;
// load, clear and range first words give no result.
// Throughput: one request at a time; a check walks the table RAM once,
// one entry per cycle through its single read port.
// Reset: synchronous, active high; empties the table and drops a pending
// pair; table contents are left as they were.
// ----------------------------------------------------------------------------
// capability_descriptor_checker_core
// Loads restriction words into a RAM and checks capability words against it.
// ----------------------------------------------------------------------------
`include "capability_descriptor_checker_core_defines.svh"

module capability_descriptor_checker_core (
  input logic clk,
  input logic rst,
  cdc_in_if.sink    in_ch,
  cdc_out_if.source out_ch
);

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_DONE, S_OUT} state_t;

  state_t                    state;
  logic [cdc_pkg::CountW-1:0] count;
  logic [cdc_pkg::CountW-1:0] idx;
  logic                      pending;
  logic [31:0]               first_w;
  logic [31:0]               cap;
  logic                      cap_last;
  logic                      is_pair;
  logic [3:0]                kind_st;
  logic                      step;
  logic                      start;
  logic                      hit;
  logic [31:0]               rdata;
  logic                      accept;
  logic                      we;
  logic [5:0]                in_kind;
  logic [cdc_pkg::AddrW-1:0] raddr;

  assign accept  = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == S_IDLE);
  assign in_kind = cdc_pkg::kind_of(in_ch.word);
  assign we      = accept && in_ch.action == cdc_pkg::ACT_LOAD &&
                   count < cdc_pkg::CountW'(cdc_pkg::TableDepth);
  assign raddr   = idx[cdc_pkg::AddrW-1:0];
  assign out_ch.valid = (state == S_OUT);

  cdc_ram #(.Width(32), .Depth(cdc_pkg::TableDepth)) u_ram (
    .clk(clk), .we(we), .waddr(count[cdc_pkg::AddrW-1:0]), .wdata(in_ch.word),
    .raddr(raddr), .rdata(rdata)
  );

  cdc_eval u_eval (
    .clk(clk), .start(start), .step(step), .entry(rdata),
    .cap(cap), .first(first_w), .pair(is_pair), .hit(hit)
  );

  // Status code for the kind of a fresh capability word
  function automatic logic [3:0] kind_status(input logic [5:0] k);
    case (k)
      6'd3:  return cdc_pkg::ST_KFLAGS;
      6'd4:  return cdc_pkg::ST_SYSCALL;
      6'd6:  return cdc_pkg::ST_RANGE;
      6'd7:  return cdc_pkg::ST_PAGE;
      6'd10: return cdc_pkg::ST_REGION;
      6'd11: return cdc_pkg::ST_IRQ;
      6'd13: return cdc_pkg::ST_APPTYPE;
      6'd14: return cdc_pkg::ST_KVER;
      6'd15: return cdc_pkg::ST_HANDLES;
      6'd16: return cdc_pkg::ST_DEBUG;
      6'd32: return cdc_pkg::ST_OK;
      default: return cdc_pkg::ST_UNKNOWN;
    endcase
  endfunction

  // Sequencer: accept requests, walk the table, present the result
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      pending <= 1'b0;
      idx     <= '0;
      step    <= 1'b0;
      start   <= 1'b0;
    end else begin
      start <= 1'b0;
      case (state)
        S_IDLE: if (accept) begin
          cap      <= in_ch.word;
          cap_last <= in_ch.last_word;
          idx      <= '0;
          case (in_ch.action)
            cdc_pkg::ACT_CLEAR: begin
              count   <= '0;
              pending <= 1'b0;
            end
            cdc_pkg::ACT_LOAD: if (we) count <= count + cdc_pkg::CountW'(1);
            cdc_pkg::ACT_CHECK: begin
              if (pending) begin
                pending <= 1'b0;
                is_pair <= 1'b1;
                kind_st <= cdc_pkg::ST_RANGE;
                start   <= 1'b1;
                state   <= S_WALK;
              end else if (in_kind == 6'd6 && !in_ch.last_word) begin
                pending <= 1'b1;
                first_w <= in_ch.word;
              end else begin
                is_pair <= 1'b0;
                kind_st <= kind_status(in_kind);
                start   <= 1'b1;
                state   <= S_WALK;
              end
            end
            default: ;
          endcase
        end
        S_WALK: begin
          step <= (idx < count);
          if (idx < count) idx <= idx + cdc_pkg::CountW'(1);
          else state <= S_DONE;
        end
        S_DONE: begin
          step  <= 1'b0;
          state <= S_OUT;
          out_ch.list_done <= cap_last;
          out_ch.status <= (kind_st == cdc_pkg::ST_OK || hit) ? cdc_pkg::ST_OK : kind_st;
        end
        S_OUT: if (out_ch.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  `CDC_ASSERT_IMPL(a_ready_idle, clk, rst, in_ch.ready, state == S_IDLE, "ready outside idle")
  `CDC_ASSERT_IMPL(a_count_max, clk, rst, 1'b1, count <= cdc_pkg::CountW'(cdc_pkg::TableDepth), "count overflow")
  `CDC_ASSERT_NEXT(a_out_done, clk, rst, state == S_DONE, out_ch.valid, "result not shown")

endmodule
